@@ rtl/toc_pkg.sv @@
// toc_pkg: shared types, constants and helper functions of the translation orbit classifier
// no dependencies; imported by toc_rotate, toc_reduce and translation_orbit_classifier_top
`default_nettype none

package toc_pkg;

    // ring size and field widths
    localparam int MAX_SITES = 63;
    localparam int W_STATE   = MAX_SITES;
    localparam int W_CNT     = 6;
    localparam int W_WIDE    = 2 * W_STATE;
    localparam int W_PROD    = 2 * W_CNT;
    localparam int LANES     = 64;
    localparam int GROUPS    = LANES / 8;

    // configuration register indexes
    localparam int             W_CFG_IDX          = 2;
    localparam logic [W_CFG_IDX-1:0] CFG_CHAIN_LENGTH   = 2'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_ONES_WANTED    = 2'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_MOMENTUM_INDEX = 2'd2;

    // configuration reset values
    localparam logic [W_CNT-1:0] RST_CHAIN_LENGTH   = 6'd8;
    localparam logic [W_CNT-1:0] RST_ONES_WANTED    = 6'd0;
    localparam logic [W_CNT-1:0] RST_MOMENTUM_INDEX = 6'd0;

    typedef logic [W_STATE-1:0] state_t;
    typedef logic [W_CNT-1:0]   cnt_t;

    localparam state_t ALL_ONES = '1;

    // all lane rotations of one request, from the rotate front end
    typedef struct packed {
        logic [LANES-1:0][W_STATE-1:0] rot;
        state_t                        state;
        cnt_t                          n;
        cnt_t                          ones;
    } rot_bus_t;

    // one candidate of the minimum tree
    typedef struct packed {
        state_t val;
        cnt_t   idx;
    } cand_t;

    // side data traveling beside the minimum tree
    typedef struct packed {
        state_t            state;
        cnt_t              n;
        cnt_t              ones;
        cnt_t              period;
        logic [W_PROD-1:0] rem;
        logic              fits;
    } side_t;

    // reduced result handed to the output stage
    typedef struct packed {
        state_t best;
        cnt_t   lbest;
        state_t state;
        cnt_t   n;
        cnt_t   period;
        cnt_t   ones;
        logic   fits;
    } red_out_t;

    // smaller value wins, ties keep the lower lane on the left
    function automatic cand_t cand_pick(cand_t left, cand_t right);
        return (right.val < left.val) ? right : left;
    endfunction

    // population count of one byte
    function automatic logic [3:0] count8(logic [7:0] x);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++) begin
            c = c + {3'b000, x[i]};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/translation_orbit_classifier_top.sv @@
// translation_orbit_classifier_top: configuration registers, front end, minimum tree
// and output register; depends on toc_pkg, toc_rotate and toc_reduce
//
// Usage:
//   Input channel s_valid/s_ready carries one basis state per request on
//   s_state_bits; bits at chain_length and above are ignored. Result channel
//   m_valid/m_ready returns one result per request, in order.
//   Configuration is written through cfg_write/cfg_index/cfg_wdata while no
//   request is in flight: index 0 chain_length, 1 ones_wanted, 2 momentum_index;
//   other indexes are ignored.
//   From acceptance to m_valid a request passes three front-end stages for
//   masking, rotation and popcount, six minimum-tree levels over 64 lanes and one
//   output register, the first stage loading at the accepting edge.
//   Throughput: one request per cycle while m_ready takes the results, set by the one-level compare per tree stage.
//   Reset (aresetn low, synchronous) empties every stage and restores
//   chain_length 8, ones_wanted 0, momentum_index 0.
//   When m_ready is low, results stay in the output register and each stage
//   keeps accepting until the stages ahead are full; s_ready drops only when
//   all ten stages hold a request.
`default_nettype none

module translation_orbit_classifier_top
    import toc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_write,
    input  wire logic [W_CFG_IDX-1:0] cfg_index,
    input  wire logic [W_CNT-1:0]     cfg_wdata,
    // input requests
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [W_STATE-1:0]   s_state_bits,
    // results
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [W_STATE-1:0]        m_representative,
    output logic [W_CNT-1:0]          m_shift_to_state,
    output logic [W_CNT-1:0]          m_orbit_period,
    output logic [W_CNT-1:0]          m_ones_count,
    output logic                      m_is_own_representative,
    output logic                      m_momentum_fits,
    output logic                      m_accepted,
    output logic                      m_settings_invalid
);

    cnt_t chain_length_reg, ones_wanted_reg, momentum_index_reg;

    logic     rot_valid, rot_ready;
    rot_bus_t rot_bus;
    logic     red_valid, red_ready;
    red_out_t red_bus;

    logic   out_vld_reg, out_vld_next, out_load;
    state_t out_rep_reg;
    cnt_t   out_shift_reg, out_shift_next;
    cnt_t   out_period_reg, out_ones_reg;
    logic   out_own_reg, out_own_next;
    logic   out_fits_reg;
    logic   out_acc_reg, out_acc_next;
    logic   out_inv_reg, settings_bad;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_length_reg   <= RST_CHAIN_LENGTH;
            ones_wanted_reg    <= RST_ONES_WANTED;
            momentum_index_reg <= RST_MOMENTUM_INDEX;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_CHAIN_LENGTH:   chain_length_reg   <= cfg_wdata;
                CFG_ONES_WANTED:    ones_wanted_reg    <= cfg_wdata;
                CFG_MOMENTUM_INDEX: momentum_index_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // front end: mask, doubled word, lane rotations, popcount
    toc_rotate u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_state  (s_state_bits),
        .chain_n   (chain_length_reg),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_bus   (rot_bus)
    );

    // minimum tree with period and momentum side path
    toc_reduce u_reduce (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (rot_valid),
        .in_ready       (rot_ready),
        .in_bus         (rot_bus),
        .momentum_index (momentum_index_reg),
        .out_valid      (red_valid),
        .out_ready      (red_ready),
        .out_bus        (red_bus)
    );

    // settings check
    assign settings_bad = (chain_length_reg == '0)
                       || (ones_wanted_reg > chain_length_reg)
                       || (momentum_index_reg >= chain_length_reg);

    // final flags and shift back to the state
    always_comb begin : finish
        out_load       = !out_vld_reg || m_ready;
        out_vld_next   = out_load ? red_valid : out_vld_reg;
        out_shift_next = (red_bus.lbest == '0) ? '0 : red_bus.n - red_bus.lbest;
        out_own_next   = (red_bus.state == red_bus.best);
        out_acc_next   = out_own_next && red_bus.fits && !settings_bad
                      && (red_bus.ones == ones_wanted_reg);
    end

    assign red_ready = out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_rep_reg    <= red_bus.best;
            out_shift_reg  <= out_shift_next;
            out_period_reg <= red_bus.period;
            out_ones_reg   <= red_bus.ones;
            out_own_reg    <= out_own_next;
            out_fits_reg   <= red_bus.fits;
            out_acc_reg    <= out_acc_next;
            out_inv_reg    <= settings_bad;
        end
    end

    assign m_valid                 = out_vld_reg;
    assign m_representative        = out_rep_reg;
    assign m_shift_to_state        = out_shift_reg;
    assign m_orbit_period          = out_period_reg;
    assign m_ones_count            = out_ones_reg;
    assign m_is_own_representative = out_own_reg;
    assign m_momentum_fits         = out_fits_reg;
    assign m_accepted              = out_acc_reg;
    assign m_settings_invalid      = out_inv_reg;

    // an accepted state has valid settings, is its own representative and fits the momentum
    a_accept_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_acc_reg |-> !out_inv_reg && out_own_reg && out_fits_reg)
        else $error("accepted result with a failing condition");

    // a state that is its own representative is reached by no rotation
    a_own_zero_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_own_reg |-> out_shift_reg == '0)
        else $error("own representative with nonzero shift");

    // period is never zero
    a_period_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> out_period_reg != '0)
        else $error("orbit period of zero");

    // the input stalls only when the output holds a result that is not taken
    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> out_vld_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

    // count never exceeds the ring size
    a_ones_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> out_ones_reg <= chain_length_reg)
        else $error("population count above chain length");

endmodule

`default_nettype wire

@@ rtl/toc_rotate.sv @@
// toc_rotate: three-stage front end, masks the state and builds all cyclic rotations
// depends on toc_pkg
`default_nettype none

module toc_rotate
    import toc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire state_t   in_state,
    input  wire cnt_t     chain_n,
    output logic          out_valid,
    input  wire logic     out_ready,
    output rot_bus_t      out_bus
);

    logic a_vld_reg, a_vld_next, a_load;
    logic b_vld_reg, b_vld_next, b_load;
    logic c_vld_reg, c_vld_next, c_load;

    state_t a_state_reg, a_state_next;
    cnt_t   a_n_reg;

    state_t                   b_state_reg;
    cnt_t                     b_n_reg;
    logic [W_WIDE-1:0]        b_e_reg, b_e_next;
    logic [GROUPS-1:0][3:0]   b_part_reg, b_part_next;

    rot_bus_t c_bus_reg, c_bus_next;

    // stall chain, a stage loads when empty or when its successor loads
    always_comb begin : ctrl
        c_load     = !c_vld_reg || out_ready;
        b_load     = !b_vld_reg || c_load;
        a_load     = !a_vld_reg || b_load;
        a_vld_next = a_load ? in_valid  : a_vld_reg;
        b_vld_next = b_load ? a_vld_reg : b_vld_reg;
        c_vld_next = c_load ? b_vld_reg : c_vld_reg;
    end

    assign in_ready  = a_load;
    assign out_valid = c_vld_reg;
    assign out_bus   = c_bus_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= a_vld_next;
            b_vld_reg <= b_vld_next;
            c_vld_reg <= c_vld_next;
        end
    end

    // stage a: keep only the low n bits
    assign a_state_next = in_state & ~(ALL_ONES << chain_n);

    // stage b: doubled word for rotation and byte popcounts
    always_comb begin : stage_b
        logic [LANES-1:0] padded;
        padded   = {{(LANES-W_STATE){1'b0}}, a_state_reg};
        b_e_next = {{W_STATE{1'b0}}, a_state_reg}
                 | ({{W_STATE{1'b0}}, a_state_reg} << a_n_reg);
        for (int g = 0; g < GROUPS; g++) begin
            b_part_next[g] = count8(padded[8*g +: 8]);
        end
    end

    // stage c: one rotation per lane, lane zero always holds the masked state,
    // other lanes at or past n are parked at all ones
    always_comb begin : stage_c
        state_t            mask_b;
        logic [W_WIDE-1:0] sh;
        cnt_t              ones;
        mask_b = ~(ALL_ONES << b_n_reg);
        ones   = '0;
        for (int g = 0; g < GROUPS; g++) begin
            ones = ones + {{(W_CNT-4){1'b0}}, b_part_reg[g]};
        end
        c_bus_next.state = b_state_reg;
        c_bus_next.n     = b_n_reg;
        c_bus_next.ones  = ones;
        for (int l = 0; l < LANES; l++) begin
            sh = (b_e_reg << l) >> b_n_reg;
            if ((l == 0) || ((W_CNT+1)'(l) < {1'b0, b_n_reg})) begin
                c_bus_next.rot[l] = sh[W_STATE-1:0] & mask_b;
            end else begin
                c_bus_next.rot[l] = ALL_ONES;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_state_reg <= a_state_next;
            a_n_reg     <= chain_n;
        end
        if (b_load) begin
            b_state_reg <= a_state_reg;
            b_n_reg     <= a_n_reg;
            b_e_reg     <= b_e_next;
            b_part_reg  <= b_part_next;
        end
        if (c_load) begin
            c_bus_reg <= c_bus_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/toc_reduce.sv @@
// toc_reduce: six-stage registered minimum tree over the rotations, with the
// period search and the momentum remainder carried alongside; depends on toc_pkg
`default_nettype none

module toc_reduce
    import toc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire rot_bus_t in_bus,
    input  wire cnt_t     momentum_index,
    output logic          out_valid,
    input  wire logic     out_ready,
    output red_out_t      out_bus
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] vld_reg, vld_next, load;

    cand_t leaf [LANES];
    cand_t lv1_reg [32], lv1_next [32];
    cand_t lv2_reg [16], lv2_next [16];
    cand_t lv3_reg [8],  lv3_next [8];
    cand_t lv4_reg [4],  lv4_next [4];
    cand_t lv5_reg [2],  lv5_next [2];
    cand_t lv6_reg,      lv6_next;

    logic [W_STATE-1:1] eq_reg, eq_next;
    side_t sd_reg [STAGES];
    side_t sd_next [STAGES];

    // stall chain
    always_comb begin : ctrl
        load[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            load[i] = !vld_reg[i] || load[i+1];
        end
        vld_next[0] = load[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < STAGES; i++) begin
            vld_next[i] = load[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign in_ready  = load[0];
    assign out_valid = vld_reg[STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // leaves tagged with their rotation count
    always_comb begin : leaves
        for (int l = 0; l < LANES; l++) begin
            leaf[l].val = in_bus.rot[l];
            leaf[l].idx = W_CNT'(l);
        end
    end

    // tree levels, one compare per stage
    always_comb begin : tree
        for (int i = 0; i < 32; i++) lv1_next[i] = cand_pick(leaf[2*i], leaf[2*i+1]);
        for (int i = 0; i < 16; i++) lv2_next[i] = cand_pick(lv1_reg[2*i], lv1_reg[2*i+1]);
        for (int i = 0; i < 8; i++)  lv3_next[i] = cand_pick(lv2_reg[2*i], lv2_reg[2*i+1]);
        for (int i = 0; i < 4; i++)  lv4_next[i] = cand_pick(lv3_reg[2*i], lv3_reg[2*i+1]);
        for (int i = 0; i < 2; i++)  lv5_next[i] = cand_pick(lv4_reg[2*i], lv4_reg[2*i+1]);
        lv6_next = cand_pick(lv5_reg[0], lv5_reg[1]);
    end

    // rotations that map the state onto itself
    always_comb begin : self_match
        for (int l = 1; l < W_STATE; l++) begin
            eq_next[l] = (in_bus.rot[l] == in_bus.state)
                       && ((W_CNT+1)'(l) < {1'b0, in_bus.n});
        end
    end

    // side path: period, product, remainder steps, fit flag
    always_comb begin : side
        logic [W_PROD-1:0] d;
        sd_next[0].state  = in_bus.state;
        sd_next[0].n      = in_bus.n;
        sd_next[0].ones   = in_bus.ones;
        sd_next[0].period = '0;
        sd_next[0].rem    = '0;
        sd_next[0].fits   = 1'b0;

        // first self match wins, no match leaves period n, empty ring gives one
        sd_next[1] = sd_reg[0];
        sd_next[1].period = (sd_reg[0].n == '0) ? W_CNT'(1) : sd_reg[0].n;
        for (int l = W_STATE - 1; l >= 1; l--) begin
            if (eq_reg[l]) begin
                sd_next[1].period = W_CNT'(l);
            end
        end

        // momentum times period
        sd_next[2] = sd_reg[1];
        sd_next[2].rem = {{W_CNT{1'b0}}, momentum_index}
                       * {{W_CNT{1'b0}}, sd_reg[1].period};

        // upper remainder steps
        sd_next[3] = sd_reg[2];
        for (int j = W_CNT - 1; j >= W_CNT / 2; j--) begin
            d = {{W_CNT{1'b0}}, sd_reg[2].n} << j;
            if (sd_next[3].rem >= d) begin
                sd_next[3].rem = sd_next[3].rem - d;
            end
        end

        // lower remainder steps
        sd_next[4] = sd_reg[3];
        for (int j = W_CNT / 2 - 1; j >= 0; j--) begin
            d = {{W_CNT{1'b0}}, sd_reg[3].n} << j;
            if (sd_next[4].rem >= d) begin
                sd_next[4].rem = sd_next[4].rem - d;
            end
        end

        // multiple of n when the remainder is gone
        sd_next[5] = sd_reg[4];
        sd_next[5].fits = (sd_reg[4].n != '0) && (sd_reg[4].rem == '0);
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (load[0]) begin
            lv1_reg   <= lv1_next;
            eq_reg    <= eq_next;
            sd_reg[0] <= sd_next[0];
        end
        if (load[1]) begin
            lv2_reg   <= lv2_next;
            sd_reg[1] <= sd_next[1];
        end
        if (load[2]) begin
            lv3_reg   <= lv3_next;
            sd_reg[2] <= sd_next[2];
        end
        if (load[3]) begin
            lv4_reg   <= lv4_next;
            sd_reg[3] <= sd_next[3];
        end
        if (load[4]) begin
            lv5_reg   <= lv5_next;
            sd_reg[4] <= sd_next[4];
        end
        if (load[5]) begin
            lv6_reg   <= lv6_next;
            sd_reg[5] <= sd_next[5];
        end
    end

    assign out_bus.best   = lv6_reg.val;
    assign out_bus.lbest  = lv6_reg.idx;
    assign out_bus.state  = sd_reg[STAGES-1].state;
    assign out_bus.n      = sd_reg[STAGES-1].n;
    assign out_bus.period = sd_reg[STAGES-1].period;
    assign out_bus.ones   = sd_reg[STAGES-1].ones;
    assign out_bus.fits   = sd_reg[STAGES-1].fits;

endmodule

`default_nettype wire
